// ===== src/spa_pkg.sv =====
// Shared types, constants and helpers for the saturation primaries adjust block.
`default_nettype none
package spa_pkg;

  localparam int unsigned Lanes     = 9;
  localparam int unsigned SatW      = 17;
  localparam int unsigned CompW     = 32;
  localparam int unsigned DenW      = 30;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned InDataW   = 312;
  localparam int unsigned OutDataW  = 288;

  localparam logic [SatW-1:0]  SatMin   = 17'd13107;
  localparam logic [SatW-1:0]  SatMax   = 17'd65536;
  localparam logic [13:0]      LumaDen  = 14'd10000;
  localparam logic signed [31:0] T1Scale = 32'sd655360000;

  localparam logic [CompW-1:0] PosLimit = 32'h7FFF_FFFF;
  localparam logic [CompW-1:0] NegLimit = 32'h8000_0000;

  typedef struct packed {
    logic [DenW-1:0]                 den;
    logic [Lanes-1:0]                neg;
    logic [Lanes-1:0]                ovf;
    logic [Lanes-1:0][DenW-1:0]      rem;
    logic [Lanes-1:0][CompW-1:0]     quo;
  } div_t;

  function automatic logic [12:0] luma_num(input logic [1:0] idx);
    logic [12:0] r;
    case (idx)
      2'd0:    r = 13'd2126;
      2'd1:    r = 13'd7152;
      2'd2:    r = 13'd722;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/spa_front.sv =====
// Front pipeline: clamp, row sums, products, numerator and rounding bias.
`default_nettype none
module spa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [spa_pkg::SatW-1:0]          sat_i,
  input  logic [spa_pkg::Lanes-1:0][31:0]   comp_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output spa_pkg::div_t                     data_o
);
  import spa_pkg::*;

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic ena, enb, enc, en_d, ene;

  // stage A
  logic signed [31:0] a_m_q   [Lanes];
  logic signed [33:0] a_rs_q  [3];
  logic [SatW-1:0]    a_om_q;
  logic [DenW-1:0]    a_den_q;
  // stage B
  logic signed [61:0] b_t1_q  [Lanes];
  logic signed [33:0] b_rs_q  [3];
  logic [28:0]        b_p_q   [3];
  logic [DenW-1:0]    b_den_q;
  // stage C
  logic signed [61:0] c_t1_q  [Lanes];
  logic signed [62:0] c_t2_q  [Lanes];
  logic [DenW-1:0]    c_den_q;
  // stage D
  logic [62:0]        d_mag_q [Lanes];
  logic [Lanes-1:0]   d_neg_q;
  logic [DenW-1:0]    d_den_q;
  // stage E
  div_t               e_q;

  assign ene     = !ve_q || ready_i;
  assign en_d    = !vd_q || ene;
  assign enc     = !vc_q || en_d;
  assign enb     = !vb_q || enc;
  assign ena     = !va_q || enb;
  assign ready_o = ena;
  assign valid_o = ve_q;
  assign data_o  = e_q;

  logic [SatW-1:0] sat_c;
  logic [30:0]     den_c;
  always_comb begin
    sat_c = sat_i;
    if (sat_i < SatMin) sat_c = SatMin;
    if (sat_i > SatMax) sat_c = SatMax;
    den_c = 31'(sat_c * LumaDen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ena)  va_q <= valid_i;
      if (enb)  vb_q <= va_q;
      if (enc)  vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
      if (ene)  ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      for (int k = 0; k < Lanes; k++) a_m_q[k] <= $signed(comp_i[k]);
      for (int i = 0; i < 3; i++) begin
        a_rs_q[i] <= 34'($signed(comp_i[i])) + 34'($signed(comp_i[3+i]))
                   + 34'($signed(comp_i[6+i]));
      end
      a_om_q  <= SatMax - sat_c;
      a_den_q <= den_c[DenW-1:0];
    end
  end

  logic signed [63:0] t1_c [Lanes];
  always_comb begin
    for (int k = 0; k < Lanes; k++) t1_c[k] = a_m_q[k] * T1Scale;
  end

  always_ff @(posedge clk_i) begin
    if (enb) begin
      for (int k = 0; k < Lanes; k++) b_t1_q[k] <= t1_c[k][61:0];
      for (int j = 0; j < 3; j++) begin
        b_p_q[j]  <= 29'(a_om_q * luma_num(2'(j)));
        b_rs_q[j] <= a_rs_q[j];
      end
      b_den_q <= a_den_q;
    end
  end

  logic signed [63:0] t2_c [Lanes];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        t2_c[j*3+i] = $signed({1'b0, b_p_q[j]}) * b_rs_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc) begin
      for (int k = 0; k < Lanes; k++) begin
        c_t1_q[k] <= b_t1_q[k];
        c_t2_q[k] <= t2_c[k][62:0];
      end
      c_den_q <= b_den_q;
    end
  end

  logic signed [63:0] num_c [Lanes];
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      num_c[k] = 64'(c_t1_q[k]) - 64'(c_t2_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      for (int k = 0; k < Lanes; k++) begin
        d_neg_q[k] <= num_c[k][63];
        d_mag_q[k] <= num_c[k][63] ? 63'(-num_c[k]) : num_c[k][62:0];
      end
      d_den_q <= c_den_q;
    end
  end

  logic [62:0] adj_c [Lanes];
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      adj_c[k] = d_mag_q[k] + 63'(d_den_q[DenW-1:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ene) begin
      for (int k = 0; k < Lanes; k++) begin
        e_q.ovf[k] <= adj_c[k][62:32] >= 31'(d_den_q);
        e_q.rem[k] <= adj_c[k][61:32];
        e_q.quo[k] <= adj_c[k][31:0];
      end
      e_q.neg <= d_neg_q;
      e_q.den <= d_den_q;
    end
  end

`ifndef SYNTHESIS
  a_den_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> (a_den_q >= 30'd131070000 && a_den_q <= 30'd655360000))
    else $error("denominator out of range");
`endif

endmodule
`default_nettype wire

// ===== src/spa_div_stage.sv =====
// One restoring division step for all lanes, with its own pipeline register.
`default_nettype none
module spa_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  spa_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output spa_pkg::div_t data_o
);
  import spa_pkg::*;

  logic  v_q;
  div_t  d_q;
  div_t  d_n;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;

  logic [DenW:0] sh [Lanes];
  logic [DenW:0] df [Lanes];
  always_comb begin
    d_n = data_i;
    for (int k = 0; k < Lanes; k++) begin
      sh[k] = {data_i.rem[k], data_i.quo[k][CompW-1]};
      df[k] = sh[k] - {1'b0, data_i.den};
      if (sh[k] >= {1'b0, data_i.den}) begin
        d_n.rem[k] = df[k][DenW-1:0];
        d_n.quo[k] = {data_i.quo[k][CompW-2:0], 1'b1};
      end else begin
        d_n.rem[k] = sh[k][DenW-1:0];
        d_n.quo[k] = {data_i.quo[k][CompW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) d_q <= d_n;
  end

`ifndef SYNTHESIS
  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < Lanes; k++) begin
      if (!d_q.ovf[k] && d_q.rem[k] >= d_q.den) rem_ok = 1'b0;
    end
  end
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> rem_ok)
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ===== src/spa_out.sv =====
// Output stage: sign restore and saturation to the signed 32-bit range.
`default_nettype none
module spa_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  spa_pkg::div_t                         data_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [spa_pkg::Lanes-1:0][31:0]       comp_o
);
  import spa_pkg::*;

  logic                         v_q;
  logic [Lanes-1:0][CompW-1:0]  r_q;
  logic [Lanes-1:0][CompW-1:0]  r_d;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign comp_o  = r_q;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      if (data_i.neg[k]) begin
        if (data_i.ovf[k] || data_i.quo[k] > NegLimit) r_d[k] = NegLimit;
        else                                             r_d[k] = -data_i.quo[k];
      end else begin
        if (data_i.ovf[k] || data_i.quo[k] > PosLimit) r_d[k] = PosLimit;
        else                                             r_d[k] = data_i.quo[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) r_q <= r_d;
  end

endmodule
`default_nettype wire

// ===== src/saturation_primaries_adjust.sv =====
// Top level of the saturation primaries adjust pipeline.
// Takes one request per cycle unless the output stalls and returns the adjusted primaries
// through five front stages (clamp and row sums, the two multiplier stages, numerator,
// rounding bias with overflow check), 32 restoring divide stages that form one
// quotient bit each for all nine elements, and an output saturation register.
// Every stage holds its own valid bit, so a stall on the output fills bubbles
// before it pushes back on the input.
`default_nettype none
module saturation_primaries_adjust (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // saturation_q16[16:0], in_red_x, in_red_y, in_red_z, in_green_x, in_green_y,
  // in_green_z, in_blue_x, in_blue_y, in_blue_z (32 bits each), zero pad [311:305]
  input  logic [spa_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_red_x, out_red_y, out_red_z, out_green_x, out_green_y, out_green_z,
  // out_blue_x, out_blue_y, out_blue_z (32 bits each)
  output logic [spa_pkg::OutDataW-1:0]  m_axis_tdata
);
  import spa_pkg::*;

  logic [Lanes-1:0][31:0] comp_in;
  logic [Lanes-1:0][31:0] comp_out;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      comp_in[k] = s_axis_tdata[SatW + CompW*k +: CompW];
      m_axis_tdata[CompW*k +: CompW] = comp_out[k];
    end
  end

  logic  vld [DivSteps+1];
  logic  rdy [DivSteps+1];
  div_t  dat [DivSteps+1];

  spa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .sat_i   (s_axis_tdata[SatW-1:0]),
    .comp_i  (comp_in),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .data_o  (dat[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    spa_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .data_i  (dat[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .data_o  (dat[g+1])
    );
  end

  spa_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[DivSteps]),
    .ready_o (rdy[DivSteps]),
    .data_i  (dat[DivSteps]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .comp_o  (comp_out)
  );

`ifndef SYNTHESIS
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for saturation_primaries_adjust: predicts each adjusted matrix and checks it.
`default_nettype none

class primaries_scoreboard;
  logic [spa_pkg::OutDataW-1:0] pending_q[$];
  int unsigned fail_cnt;
  int unsigned matrices_checked;
  int unsigned clamp_cnt;
  int unsigned sat_cnt;

  function void note_request(input logic [spa_pkg::InDataW-1:0] req);
    logic [spa_pkg::OutDataW-1:0] res;
    logic [16:0] sq;
    longint m[3][3];
    longint rsum[3];
    longint lnum[3];
    longint num;
    longint den;
    longint mag;
    longint q;
    longint omin;
    sq = req[16:0];
    lnum[0] = 2126;
    lnum[1] = 7152;
    lnum[2] = 722;
    if (sq < spa_pkg::SatMin) begin
      sq = spa_pkg::SatMin;
      clamp_cnt++;
    end
    if (sq > spa_pkg::SatMax) begin
      sq = spa_pkg::SatMax;
      clamp_cnt++;
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        m[i][j] = longint'($signed(req[17 + (j * 3 + i) * 32 +: 32]));
      end
    end
    for (int i = 0; i < 3; i++) rsum[i] = m[i][0] + m[i][1] + m[i][2];
    omin = 65536 - longint'(sq);
    den = longint'(sq) * 10000;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        num = m[i][j] * 655360000 - omin * lnum[j] * rsum[i];
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0) begin
          if (q > 64'sh8000_0000) begin
            q = 64'sh8000_0000;
            sat_cnt++;
          end
          q = -q;
        end else if (q > 64'sh7FFF_FFFF) begin
          q = 64'sh7FFF_FFFF;
          sat_cnt++;
        end
        res[(j * 3 + i) * 32 +: 32] = q[31:0];
      end
    end
    pending_q.push_back(res);
  endfunction

  function void check_result(input logic [spa_pkg::OutDataW-1:0] got);
    logic [spa_pkg::OutDataW-1:0] exp_v;
    string names[9];
    names = '{"out_red_x", "out_red_y", "out_red_z", "out_green_x", "out_green_y",
              "out_green_z", "out_blue_x", "out_blue_y", "out_blue_z"};
    if (pending_q.size() == 0) begin
      $error("result with no request outstanding: %h", got);
      fail_cnt++;
      return;
    end
    exp_v = pending_q.pop_front();
    matrices_checked++;
    for (int k = 0; k < 9; k++) begin
      if (got[k * 32 +: 32] !== exp_v[k * 32 +: 32]) begin
        $error("%s: expected %h, got %h", names[k], exp_v[k * 32 +: 32], got[k * 32 +: 32]);
        fail_cnt++;
      end
    end
  endfunction
endclass

module testbench;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [spa_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [spa_pkg::OutDataW-1:0] m_axis_tdata;

  primaries_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit recv_on = 1'b0;

  saturation_primaries_adjust u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      3, 4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_sat();
    case ($urandom_range(0, 7))
      0: return 17'($urandom_range(0, 13107));
      1: return 17'($urandom_range(65536, 131071));
      2: return $urandom_range(0, 1) ? 17'd13107 : 17'd65536;
      default: return 17'($urandom_range(13107, 65536));
    endcase
  endfunction

  task automatic send_request(input logic [16:0] sat, input logic [31:0] comps[9]);
    logic [spa_pkg::InDataW-1:0] d;
    d = '0;
    d[16:0] = sat;
    for (int k = 0; k < 9; k++) d[17 + k * 32 +: 32] = comps[k];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(d);
  endtask

  task automatic send_random(input int n);
    logic [31:0] c[9];
    for (int t = 0; t < n; t++) begin
      for (int k = 0; k < 9; k++) c[k] = rand_comp();
      send_request(rand_sat(), c);
    end
  endtask

  always @(posedge clk_i) begin
    if (recv_on) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL saturation_primaries_adjust");
    $finish;
  end

  initial begin
    logic [31:0] c[9];
    int wait_cnt;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    recv_on = 1'b1;
    @(posedge clk_i);
    // directed: saturation extremes, component extremes, zero and identity
    for (int k = 0; k < 9; k++) c[k] = 32'h7FFF_FFFF;
    send_request(17'd0, c);
    send_request(17'd13107, c);
    send_request(17'd65536, c);
    send_request(17'h1FFFF, c);
    for (int k = 0; k < 9; k++) c[k] = 32'h8000_0000;
    send_request(17'd0, c);
    send_request(17'd13106, c);
    send_request(17'd65537, c);
    for (int k = 0; k < 9; k++) c[k] = '0;
    send_request(17'd32768, c);
    for (int k = 0; k < 9; k++) c[k] = (k % 4 == 0) ? 32'h0001_0000 : 32'h0;
    send_request(17'd13107, c);
    send_request(17'd40000, c);
    for (int k = 0; k < 9; k++) c[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_request(17'd13107, c);
    send_request(17'd65535, c);
    for (int k = 0; k < 9; k++) c[k] = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0001;
    send_request(17'd13107, c);
    send_request(17'd1, c);
    for (int k = 0; k < 9; k++) c[k] = 32'h5555_5555 << (k % 2);
    send_request(17'h0AAAA, c);
    send_request(17'h15555, c);
    // random phases
    send_random(200);
    send_idle_pct = 60;
    send_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    send_random(200);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    send_random(150);
    // long receiver hold-off so the pipeline fills and stalls the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(100);
    join
    send_random(100);
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (sb.pending_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (60) @(posedge clk_i);
    $display("Checked %0d adjusted matrices; %0d saturation clamps, %0d saturated elements.",
             sb.matrices_checked, sb.clamp_cnt, sb.sat_cnt);
    $display("Phases: free flow, sender gaps, receiver stalls, mixed, and a long hold-off.");
    if (sb.fail_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("PASS saturation_primaries_adjust");
    end else begin
      $display("FAIL saturation_primaries_adjust");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/spa_pkg.sv
src/spa_front.sv
src/spa_div_stage.sv
src/spa_out.sv
src/saturation_primaries_adjust.sv
tb/testbench.sv
